FILE: rtl/core/iff_pkg.sv
// Package for the integer field formatter: command codes, widths, digit helpers.
// No dependencies.
`timescale 1ns / 1ps
package iff_pkg;
  localparam int DefMaxWidth = 32;
  localparam int NumCells = 10;
  localparam logic [2:0] CMD_SDEC = 3'd0;
  localparam logic [2:0] CMD_UDEC = 3'd1;
  localparam logic [2:0] CMD_LHEX = 3'd2;
  localparam logic [2:0] CMD_UHEX = 3'd3;
  localparam logic [2:0] CMD_PTR  = 3'd4;
  localparam logic [2:0] CMD_CHAR = 3'd5;

  typedef struct packed {
    logic       load;
    logic       shift;
    logic       hex;
  } cell_ctl_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] r;
    if (d < 4'd10) r = 8'h30 + {4'd0, d};
    else if (upper) r = 8'h37 + {4'd0, d};
    else r = 8'h57 + {4'd0, d};
    return r;
  endfunction
endpackage

FILE: rtl/core/iff_if.sv
// Valid/ready channel interfaces for the formatter.
// Depends on nothing.
`timescale 1ns / 1ps
interface iff_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [31:0] value;
  logic [5:0]  width;
  logic        left_just;
  logic        zero_pad;
  modport source(output valid, command, value, width, left_just, zero_pad, input ready);
  modport sink(input valid, command, value, width, left_just, zero_pad, output ready);
endinterface

interface iff_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last;
  modport source(output valid, character, last, input ready);
  modport sink(input valid, character, last, output ready);
endinterface

FILE: rtl/core/integer_field_formatter.sv
// Integer field formatter top level: conversion sequencer over a chain of
// digit cells. Depends on iff_pkg, iff_if, iff_cell.
`timescale 1ns / 1ps
// Usage: one conversion word enters on in (command, value, width, flags);
// ASCII characters leave on out, one per word, last marking the final one.
// An item is taken only when the block is idle. It first runs its conversion
// through the ten-cell digit chain (one value bit per cycle), then emits its
// characters one per cycle while out is not stalled, through the single
// output port. The first character enters the output register in the emit
// state, once the conversion state has shifted in every value bit.
// Commands 6 and 7, and a zero character with width 0, give no words.
// Reset returns the sequencer to idle and drops any pending output.
// A stall on out holds the current character; the sequencer advances only
// when the output register is free or being taken.
module integer_field_formatter
  import iff_pkg::*;
#(
  parameter int MAX_WIDTH = DefMaxWidth
) (
  input logic clk,
  input logic rst_n,
  iff_in_if.sink   in_ch,
  iff_out_if.source out_ch
);
  localparam int WW = $clog2(MAX_WIDTH + 13);
  localparam logic [1:0] S_IDLE = 2'd0, S_CONV = 2'd1, S_EMIT = 2'd2;

  logic [1:0]  st_r, st_nxt;
  logic [2:0]  cmd_r;
  logic [31:0] sh_r, sh_nxt;
  logic [WW-1:0] wid_r, pos_r, pos_nxt;
  logic        left_r, zero_r, neg_r;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [7:0]  ch_r, ch_nxt;
  logic        last_r, last_nxt, ov_r, ov_nxt;
  cell_ctl_t   ctl;
  logic [NumCells:0] carry;
  logic [3:0]  dig [NumCells];
  logic hex, upper, ptr, is_char, take, adv, neg_in, no_words;
  logic [3:0] nd_c;
  logic [WW-1:0] tlen, pad, pre, p, tot_c;
  logic [3:0] didx;
  logic [7:0] ch_c;

  genvar g;
  assign carry[0] = sh_r[31];
  generate
    for (g = 0; g < NumCells; g++) begin : g_chain
      iff_cell u_cell (.clk(clk), .ctl(ctl), .bit_in(carry[g]),
        .bit_out(carry[g+1]), .digit(dig[g]));
    end
  endgenerate

  assign hex = (cmd_r == CMD_LHEX) || (cmd_r == CMD_UHEX) || (cmd_r == CMD_PTR);
  assign upper = (cmd_r == CMD_UHEX);
  assign ptr = (cmd_r == CMD_PTR);
  assign is_char = (cmd_r == CMD_CHAR);
  assign in_ch.ready = (st_r == S_IDLE);
  assign take = in_ch.valid && in_ch.ready;
  assign adv = !ov_r || out_ch.ready;
  assign neg_in = (in_ch.command == CMD_SDEC) && in_ch.value[31];
  // no characters at all: unused command, or a zero character in a zero field
  assign no_words = (cmd_r > CMD_CHAR) ||
                    (is_char && sh_r[7:0] == 8'd0 && wid_r == '0);

  // Hex digits: the chain acts as a plain shift register across cells.
  // count significant digits from the top cell; the chain holds still
  // while characters are emitted
  always_comb begin
    nd_c = 4'd1;
    for (int i = 1; i < NumCells; i++) if (dig[i] != 4'd0) nd_c = 4'(i + 1);
  end

  always_comb begin
    tlen = is_char ? WW'(sh_r[7:0] != 8'd0) : WW'(nd_c) + WW'(neg_r);
    pad = (wid_r > tlen) ? wid_r - tlen : '0;
    pre = ptr ? WW'(2) : '0;
    p = pos_r;
    didx = '0;
    ch_c = 8'h20;
    if (p < pre) ch_c = (p == '0) ? 8'h30 : 8'h78;
    else begin
      p = p - pre;
      if (!left_r && !zero_r && !is_char) begin
        if (p < pad) ch_c = 8'h20;
        else begin
          p = p - pad;
          if (neg_r && p == '0) ch_c = 8'h2d;
          else begin
            didx = 4'(WW'(nd_c) - WW'(1) - (p - WW'(neg_r)));
            ch_c = digit_char(dig[didx], upper);
          end
        end
      end else if (is_char) begin
        if (!left_r && p < pad) ch_c = 8'h20;
        else if (!left_r || p != '0 || tlen == '0) ch_c = 8'h20;
        else ch_c = sh_r[7:0];
        if (!left_r && p >= pad) ch_c = sh_r[7:0];
      end else begin
        if (neg_r && p == '0) ch_c = 8'h2d;
        else begin
          p = p - WW'(neg_r);
          if (!left_r && p < pad) ch_c = 8'h30;
          else begin
            if (!left_r) p = p - pad;
            if (p < WW'(nd_c)) begin
              didx = 4'(WW'(nd_c) - WW'(1) - p);
              ch_c = digit_char(dig[didx], upper);
            end else ch_c = 8'h20;
          end
        end
      end
    end
  end

  // total characters, valid once the chain has settled
  always_comb begin
    tot_c = ((wid_r > tlen) ? wid_r : tlen) + pre;
  end

  always_comb begin
    st_nxt = st_r; sh_nxt = sh_r; cnt_nxt = cnt_r; pos_nxt = pos_r;
    ch_nxt = ch_r; last_nxt = last_r;
    // drop the held word once it is taken
    ov_nxt = out_ch.ready ? 1'b0 : ov_r;
    ctl = '{load: 1'b0, shift: 1'b0, hex: hex};
    unique case (st_r)
      S_IDLE: if (take) begin
        ctl.load = 1'b1;
        sh_nxt = neg_in ? 32'd0 - in_ch.value : in_ch.value;
        cnt_nxt = '0;
        pos_nxt = '0;
        st_nxt = S_CONV;
      end
      S_CONV: begin
        ctl.shift = !is_char;
        sh_nxt = is_char ? sh_r : {sh_r[30:0], 1'b0};
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd31) st_nxt = no_words ? S_IDLE : S_EMIT;
      end
      S_EMIT: if (adv) begin
        // advance one character into the output register
        ch_nxt = ch_c;
        last_nxt = (pos_r + WW'(1) == tot_c);
        ov_nxt = 1'b1;
        pos_nxt = pos_r + WW'(1);
        if (pos_r + WW'(1) == tot_c) st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt; ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r <= sh_nxt; cnt_r <= cnt_nxt; pos_r <= pos_nxt;
    ch_r <= ch_nxt; last_r <= last_nxt;
    if (take) begin
      cmd_r <= in_ch.command;
      left_r <= in_ch.left_just; zero_r <= in_ch.zero_pad;
      wid_r <= (in_ch.width > 6'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(in_ch.width);
      neg_r <= neg_in;
    end
  end

  assign out_ch.valid = ov_r;
  assign out_ch.character = ch_r;
  assign out_ch.last = last_r;
endmodule

FILE: rtl/core/iff_cell.sv
// One digit cell of the conversion chain: holds a 4-bit digit, shifts one
// bit per cycle while ctl.shift is set, in from its lower neighbor (double-dabble or hex shift).
`timescale 1ns / 1ps
module iff_cell
  import iff_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  logic      bit_in,
  output logic      bit_out,
  output logic [3:0] digit
);
  logic [3:0] dig_r, dig_nxt, adj;
  always_comb begin
    adj = (!ctl.hex && dig_r >= 4'd5) ? dig_r + 4'd3 : dig_r;
    bit_out = adj[3];
    dig_nxt = dig_r;
    if (ctl.load) dig_nxt = 4'd0;
    else if (ctl.shift) dig_nxt = {adj[2:0], bit_in};
  end
  always_ff @(posedge clk) begin
    dig_r <= dig_nxt;
  end
  assign digit = dig_r;
endmodule
